// File: hdl/pss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pss_pkg: shared types and constants of the plucked string synthesizer
// Operation codes, register indexes, reset values, the controller state
// type and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package pss_pkg;

   localparam int MAX_LENGTH_DEFAULT = 1024;

   localparam int OP_W       = 2;
   localparam int SLOT_W     = 10;
   localparam int SAMPLE_W   = 16;
   localparam int TICK_W     = 32;
   localparam int STR_LEN_W  = 11;
   localparam int GAIN_W     = 16;
   localparam int SEED_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [STR_LEN_W-1:0] STRING_LENGTH_RESET = 11'd100;
   localparam logic [GAIN_W-1:0]    DECAY_GAIN_RESET    = 16'd65274;
   localparam logic [SEED_W-1:0]    NOISE_SEED_RESET    = 16'd12;
   localparam logic [SEED_W-1:0]    LFSR_TAPS           = 16'hB400;
   localparam int                   MIN_LENGTH          = 2;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_PLUCK = 2'd1,
      OP_LOAD  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRING_LENGTH = 2'd0,
      CSR_DECAY_GAIN    = 2'd1,
      CSR_NOISE_SEED    = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_NORM,
      ST_TICK_A,
      ST_TICK_B,
      ST_TICK_AVG,
      ST_TICK_MUL,
      ST_TICK_WR,
      ST_PLUCK,
      ST_LOAD,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic norm_step;
      logic walk_init;
      logic clr_init;
      logic rd_next;
      logic tick_cap_a;
      logic tick_cap_b;
      logic tick_mul;
      logic tick_wr;
      logic pluck_step;
      logic load_wr;
      logic fetch_cap;
      logic clr_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic   head_big;
      logic   pluck_last;
      logic   clr_last;
      op_type op;
   } sts_type;

endpackage
`default_nettype wire

// File: hdl/plucked_string_synth_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plucked_string_synth_core: Karplus-Strong plucked string voice
// Requests carry an operation (tick, pluck, load slot, clear), a slot and a
// load value; each request returns one response with the front sample and
// the tick count. Requests are taken one at a time: req_stall stays high
// until the current request has moved into the response register.
// The sequencer walks the single-port ring memory: a tick reads the head
// and next samples, averages them, scales by the decay gain and writes
// back at the head; a load writes the slot and fetches the front; a pluck
// fills the string with noise from the head; a clear zeroes the whole ring.
// A head beyond a shrunk length is first wrapped back by the length. The
// next request can be taken the cycle after the response register loads.
// The response register frees the request side: a new request is taken
// while rsp_stall holds the previous response, and the next response then
// waits until that one is taken.
// After reset the whole ring is swept to zero with req_stall high; csr
// writes are taken at any time and only while idle make sense.
// ---------------------------------------------------------------------------
module plucked_string_synth_core #(
   parameter int MAX_LENGTH = pss_pkg::MAX_LENGTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [pss_pkg::OP_W-1:0]            req_operation,
   input  wire logic [pss_pkg::SLOT_W-1:0]          req_slot,
   input  wire logic signed [pss_pkg::SAMPLE_W-1:0] req_load_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [pss_pkg::SAMPLE_W-1:0]      rsp_front_sample,
   output logic [pss_pkg::TICK_W-1:0]               rsp_tick_count,
   input  wire logic                                csr_write_enable,
   input  wire logic [pss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pss_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   pss_pkg::cmd_type cmd;
   pss_pkg::sts_type sts;

   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pss_datapath #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_slot         (req_slot),
      .req_load_value   (req_load_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_front_sample (rsp_front_sample),
      .rsp_tick_count   (rsp_tick_count)
   );

endmodule
`default_nettype wire

// File: hdl/pss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pss_ctrl: sequencer of the plucked string synthesizer
// Steps the datapath through one request at a time and owns the request
// and response handshakes.
// ---------------------------------------------------------------------------
module pss_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire pss_pkg::sts_type sts,
   output pss_pkg::cmd_type      cmd
);

   pss_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != pss_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pss_pkg::ST_INIT_CLR: begin
            if (sts.clr_last) state_in = pss_pkg::ST_IDLE;
         end
         pss_pkg::ST_IDLE: begin
            if (req_valid) state_in = pss_pkg::ST_NORM;
         end
         pss_pkg::ST_NORM: begin
            if (!sts.head_big) begin
               unique case (sts.op)
                  pss_pkg::OP_TICK:  state_in = pss_pkg::ST_TICK_A;
                  pss_pkg::OP_PLUCK: state_in = pss_pkg::ST_PLUCK;
                  pss_pkg::OP_LOAD:  state_in = pss_pkg::ST_LOAD;
                  pss_pkg::OP_CLEAR: state_in = pss_pkg::ST_CLEAR;
                  default:           state_in = pss_pkg::ST_DONE;
               endcase
            end
         end
         pss_pkg::ST_TICK_A:     state_in = pss_pkg::ST_TICK_B;
         pss_pkg::ST_TICK_B:     state_in = pss_pkg::ST_TICK_AVG;
         pss_pkg::ST_TICK_AVG:   state_in = pss_pkg::ST_TICK_MUL;
         pss_pkg::ST_TICK_MUL:   state_in = pss_pkg::ST_TICK_WR;
         pss_pkg::ST_TICK_WR:    state_in = pss_pkg::ST_DONE;
         pss_pkg::ST_PLUCK: begin
            if (sts.pluck_last) state_in = pss_pkg::ST_DONE;
         end
         pss_pkg::ST_LOAD:       state_in = pss_pkg::ST_FETCH;
         pss_pkg::ST_FETCH:      state_in = pss_pkg::ST_FETCH_WAIT;
         pss_pkg::ST_FETCH_WAIT: state_in = pss_pkg::ST_DONE;
         pss_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = pss_pkg::ST_DONE;
         end
         pss_pkg::ST_DONE: begin
            if (rsp_free) state_in = pss_pkg::ST_IDLE;
         end
         default: state_in = pss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         pss_pkg::ST_INIT_CLR: cmd.clr_step = 1'b1;
         pss_pkg::ST_IDLE:     cmd.accept = req_valid;
         pss_pkg::ST_NORM: begin
            if (sts.head_big) begin
               cmd.norm_step = 1'b1;
            end else begin
               cmd.walk_init = (sts.op == pss_pkg::OP_PLUCK);
               cmd.clr_init  = (sts.op == pss_pkg::OP_CLEAR);
            end
         end
         pss_pkg::ST_TICK_A: ;
         pss_pkg::ST_TICK_B: begin
            cmd.tick_cap_a = 1'b1;
            cmd.rd_next    = 1'b1;
         end
         pss_pkg::ST_TICK_AVG:   cmd.tick_cap_b = 1'b1;
         pss_pkg::ST_TICK_MUL:   cmd.tick_mul   = 1'b1;
         pss_pkg::ST_TICK_WR:    cmd.tick_wr    = 1'b1;
         pss_pkg::ST_PLUCK:      cmd.pluck_step = 1'b1;
         pss_pkg::ST_LOAD:       cmd.load_wr    = 1'b1;
         pss_pkg::ST_FETCH:      ;
         pss_pkg::ST_FETCH_WAIT: cmd.fetch_cap  = 1'b1;
         pss_pkg::ST_CLEAR:      cmd.clr_step   = 1'b1;
         pss_pkg::ST_DONE:       cmd.rsp_load   = rsp_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::ST_INIT_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/pss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pss_datapath: sample ring, head pointer, tick counter and arithmetic
// Holds the ring memory, configuration registers, noise generator and the
// averaging and decay path, driven by commands from the sequencer.
// ---------------------------------------------------------------------------
module pss_datapath #(
   parameter int MAX_LENGTH = pss_pkg::MAX_LENGTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire pss_pkg::cmd_type                       cmd,
   output pss_pkg::sts_type                            sts,
   input  wire logic [pss_pkg::OP_W-1:0]               req_operation,
   input  wire logic [pss_pkg::SLOT_W-1:0]             req_slot,
   input  wire logic signed [pss_pkg::SAMPLE_W-1:0]    req_load_value,
   input  wire logic                                   csr_write_enable,
   input  wire logic [pss_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [pss_pkg::CSR_DATA_W-1:0]         csr_write_data,
   output logic signed [pss_pkg::SAMPLE_W-1:0]         rsp_front_sample,
   output logic [pss_pkg::TICK_W-1:0]                  rsp_tick_count
);

   localparam int HEAD_W = $clog2(MAX_LENGTH);
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int WIDE_W = ((LEN_W > pss_pkg::SLOT_W) ? LEN_W : pss_pkg::SLOT_W) + 1;
   localparam int SW     = pss_pkg::SAMPLE_W;
   localparam int PROD_W = SW + 1 + pss_pkg::GAIN_W;

   // configuration
   logic [pss_pkg::STR_LEN_W-1:0] string_length_ff, string_length_in;
   logic [pss_pkg::GAIN_W-1:0]    decay_gain_ff, decay_gain_in;
   logic [pss_pkg::SEED_W-1:0]    noise_seed_ff, noise_seed_in;

   // control state
   logic [HEAD_W-1:0]             head_ff, head_in;
   logic [pss_pkg::TICK_W-1:0]    ticks_ff, ticks_in;
   logic [HEAD_W-1:0]             idx_ff, idx_in;

   // payload
   logic [LEN_W-1:0]              len_ff, len_in;
   pss_pkg::op_type               op_ff, op_in;
   logic [pss_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [SW-1:0]                 load_value_ff, load_value_in;
   logic [LEN_W-1:0]              cnt_ff, cnt_in;
   logic [pss_pkg::SEED_W-1:0]    lfsr_ff, lfsr_in;
   logic [SW-1:0]                 a_ff, a_in;
   logic [SW:0]                   mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [SW-1:0]                 front_ff, front_in;
   logic [SW-1:0]                 rsp_front_ff, rsp_front_in;
   logic [pss_pkg::TICK_W-1:0]    rsp_ticks_ff, rsp_ticks_in;

   // ring memory
   logic [SW-1:0]                 ring [MAX_LENGTH];
   logic [SW-1:0]                 rd_data_ff;
   logic [HEAD_W-1:0]             rd_addr;
   logic [HEAD_W-1:0]             wr_addr;
   logic [SW-1:0]                 wr_data;
   logic                          wr_en;

   // combinational helpers
   logic [LEN_W-1:0]              len_calc;
   logic [WIDE_W-1:0]             sl_w, len_w, head_w, idx_w;
   logic [WIDE_W-1:0]             head_inc, idx_inc, slot_sum;
   logic [HEAD_W-1:0]             head_next, idx_next, load_addr, clr_next;
   logic                          slot_ok, pluck_last, clr_last;
   logic [pss_pkg::SEED_W-1:0]    lfsr_next;
   logic signed [SW:0]            sum_s, rnd_s, avg_s;
   logic [SW:0]                   avg_u;
   logic [SW-1:0]                 scaled, decayed;

   // clamp the programmed length to the supported range
   always_comb begin
      sl_w = WIDE_W'(string_length_ff);
      if (sl_w < WIDE_W'(pss_pkg::MIN_LENGTH)) begin
         len_calc = LEN_W'(pss_pkg::MIN_LENGTH);
      end else if (sl_w > WIDE_W'(MAX_LENGTH)) begin
         len_calc = LEN_W'(MAX_LENGTH);
      end else begin
         len_calc = LEN_W'(sl_w);
      end
   end

   assign len_w     = WIDE_W'(len_ff);
   assign head_w    = WIDE_W'(head_ff);
   assign idx_w     = WIDE_W'(idx_ff);
   assign head_inc  = head_w + WIDE_W'(1);
   assign idx_inc   = idx_w + WIDE_W'(1);
   assign head_next = (head_inc == len_w) ? '0 : HEAD_W'(head_inc);
   assign idx_next  = (idx_inc == len_w) ? '0 : HEAD_W'(idx_inc);
   assign slot_ok   = (WIDE_W'(slot_ff) < len_w);
   assign slot_sum  = head_w + WIDE_W'(slot_ff);
   assign load_addr = (slot_sum >= len_w) ? HEAD_W'(slot_sum - len_w) : HEAD_W'(slot_sum);
   assign pluck_last = (WIDE_W'(cnt_ff) == (len_w - WIDE_W'(1)));
   assign clr_last   = (idx_ff == HEAD_W'(MAX_LENGTH - 1));
   assign clr_next   = clr_last ? '0 : HEAD_W'(idx_inc);

   assign lfsr_next = {1'b0, lfsr_ff[pss_pkg::SEED_W-1:1]}
                      ^ (lfsr_ff[0] ? pss_pkg::LFSR_TAPS : '0);

   // average front and next, halved toward zero
   always_comb begin
      sum_s = $signed({a_ff[SW-1], a_ff}) + $signed({rd_data_ff[SW-1], rd_data_ff});
      rnd_s = sum_s + $signed({{SW{1'b0}}, sum_s[SW]});
      avg_s = rnd_s >>> 1;
      avg_u = avg_s;
   end

   assign scaled  = prod_ff[pss_pkg::GAIN_W +: SW];
   assign decayed = neg_ff ? (SW'(0) - scaled) : scaled;

   assign sts.head_big   = (head_w >= len_w);
   assign sts.pluck_last = pluck_last;
   assign sts.clr_last   = clr_last;
   assign sts.op         = op_ff;

   // memory ports
   assign rd_addr = cmd.rd_next ? head_next : head_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = '0;
      priority if (cmd.tick_wr) begin
         wr_en   = 1'b1;
         wr_addr = head_ff;
         wr_data = decayed;
      end else if (cmd.pluck_step) begin
         wr_en   = 1'b1;
         wr_data = lfsr_next;
      end else if (cmd.load_wr) begin
         wr_en   = slot_ok;
         wr_addr = load_addr;
         wr_data = load_value_ff;
      end else if (cmd.clr_step) begin
         wr_en   = 1'b1;
      end else begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) ring[wr_addr] <= wr_data;
      rd_data_ff <= ring[rd_addr];
   end

   // configuration writes
   always_comb begin
      string_length_in = string_length_ff;
      decay_gain_in    = decay_gain_ff;
      noise_seed_in    = noise_seed_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pss_pkg::CSR_STRING_LENGTH:
               string_length_in = csr_write_data[pss_pkg::STR_LEN_W-1:0];
            pss_pkg::CSR_DECAY_GAIN: decay_gain_in = csr_write_data;
            pss_pkg::CSR_NOISE_SEED: noise_seed_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // head, tick count and walk index
   always_comb begin
      head_in  = head_ff;
      ticks_in = ticks_ff;
      idx_in   = idx_ff;
      if (cmd.norm_step) head_in = HEAD_W'(head_w - len_w);
      if (cmd.walk_init) idx_in = head_ff;
      if (cmd.clr_init) idx_in = '0;
      if (cmd.pluck_step) idx_in = idx_next;
      if (cmd.tick_wr) begin
         head_in  = head_next;
         ticks_in = ticks_ff + 32'd1;
      end
      if (cmd.clr_step) begin
         idx_in = clr_next;
         if (clr_last) begin
            head_in  = '0;
            ticks_in = '0;
         end
      end
   end

   always_comb begin
      len_in        = len_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      load_value_in = load_value_ff;
      cnt_in        = cnt_ff;
      lfsr_in       = lfsr_ff;
      a_in          = a_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      front_in      = front_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_ticks_in  = rsp_ticks_ff;
      if (cmd.accept) begin
         len_in        = len_calc;
         op_in         = pss_pkg::op_type'(req_operation);
         slot_in       = req_slot;
         load_value_in = req_load_value;
      end
      if (cmd.walk_init) begin
         cnt_in  = '0;
         lfsr_in = noise_seed_ff;
      end
      if (cmd.pluck_step) begin
         cnt_in  = cnt_ff + LEN_W'(1);
         lfsr_in = lfsr_next;
         // the first noise sample lands on the head
         if (cnt_ff == '0) front_in = lfsr_next;
      end
      if (cmd.tick_cap_a) a_in = rd_data_ff;
      if (cmd.tick_cap_b) begin
         neg_in   = avg_u[SW];
         mag_in   = avg_u[SW] ? ((SW + 1)'(0) - avg_u) : avg_u;
         front_in = rd_data_ff;
      end
      if (cmd.tick_mul) prod_in = PROD_W'(mag_ff) * PROD_W'(decay_gain_ff);
      if (cmd.fetch_cap) front_in = rd_data_ff;
      if (cmd.clr_step && clr_last) front_in = '0;
      if (cmd.rsp_load) begin
         rsp_front_in = front_ff;
         rsp_ticks_in = ticks_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         string_length_ff <= pss_pkg::STRING_LENGTH_RESET;
         decay_gain_ff    <= pss_pkg::DECAY_GAIN_RESET;
         noise_seed_ff    <= pss_pkg::NOISE_SEED_RESET;
         head_ff          <= '0;
         ticks_ff         <= '0;
         idx_ff           <= '0;
      end else begin
         string_length_ff <= string_length_in;
         decay_gain_ff    <= decay_gain_in;
         noise_seed_ff    <= noise_seed_in;
         head_ff          <= head_in;
         ticks_ff         <= ticks_in;
         idx_ff           <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      load_value_ff <= load_value_in;
      cnt_ff        <= cnt_in;
      lfsr_ff       <= lfsr_in;
      a_ff          <= a_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      front_ff      <= front_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_ticks_ff  <= rsp_ticks_in;
   end

   assign rsp_front_sample = rsp_front_ff;
   assign rsp_tick_count   = rsp_ticks_ff;

endmodule
`default_nettype wire
